// ===== hw/rtl/gbm_pkg.sv =====
package gbm_pkg;

    localparam int unsigned SAMPLE_W   = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_LOG_DRIFT   = 2'd0;
    localparam cfg_idx_t REG_LOG_STD_DEV = 2'd1;

    typedef logic [31:0]        price_t;    // Q16.16
    typedef logic [31:0]        drift_t;    // signed Q4.28, kept as raw bits
    typedef logic [30:0]        std_dev_t;  // unsigned Q3.28
    typedef logic signed [47:0] dx_t;       // exponent, signed Q.40
    typedef logic [46:0]        dx_off_t;   // exponent plus bias, unsigned Q.40
    typedef logic [40:0]        rem_t;      // remainder before correction, < 2*ln2
    typedef logic [6:0]         kidx_t;     // biased power-of-two exponent
    typedef logic [29:0]        frac_t;     // Q.30 fraction, also series terms
    typedef logic [30:0]        exp_t;      // Q.30 value below 2.0

    // exponent clamp, +/-40 in Q.40
    localparam dx_t DX_LIMIT     = 48'sd43980465111040;
    localparam dx_t DX_LIMIT_NEG = -48'sd43980465111040;

    localparam logic [39:0] LN2_Q40 = 40'd762123384786;

    // bias of 58*ln2 keeps the reduced exponent index non-negative
    localparam kidx_t   K_BIAS    = 7'd58;
    localparam dx_off_t DX_OFFSET = 47'd44203156317588;

    // 1/ln2 estimate on the top 17 bits of the biased exponent
    localparam int unsigned HI_LSB      = 30;
    localparam int unsigned HI_W        = 17;
    localparam int unsigned RECIP_SHIFT = 24;
    localparam logic [14:0] RECIP_LN2   =
        15'((64'd1 << (RECIP_SHIFT + HI_LSB)) / 64'(LN2_Q40));

    localparam kidx_t Q_LEFT = 7'd88;   // index where the final shift is zero
    localparam kidx_t Q_MAX  = 7'd115;  // largest index after the clamp

    localparam int unsigned EXP_TERMS        = 14;
    localparam int unsigned TERM_RECIP_SHIFT = 31;
    localparam exp_t        ONE_Q30          = 31'h4000_0000;

    localparam price_t MAX_PRICE = 32'hFFFF_FFFF;

endpackage

// ===== hw/rtl/gbm_exact_step.sv =====
// Exact log-normal step of a geometric Brownian motion price path.
//
// Input channel s_*: current price (Q16.16) and a standard normal draw
// (Q3.12). Result channel m_*: next price (Q16.16) and a saturation flag;
// a saturated word carries the all-ones price.
// The two step constants are written through cfg_wr_en / cfg_index /
// cfg_wdata; the user must write them only while no word is in flight,
// which the block does not enforce. Index 0 is the log drift (signed Q4.28),
// index 1 the log deviation (unsigned Q3.28). Other indexes are dropped.
//
// The datapath is a 51-stage pipeline: range reduction by ln2 (6 stages),
// a 14-term exp series with three stages per term (multiply, reciprocal
// multiply for the divide, correction and accumulate), the price multiply,
// rounding and the final shift. One word is taken per cycle unless all
// stages hold words and m_ready is low.
// Each stage holds its word when the stage below it is full and stalled, so
// s_ready stays high while any stage is empty, also while m_valid waits on
// m_ready; it drops only when all stages hold words and m_ready is low.
// Reset empties the pipeline and clears the step constants.
module gbm_exact_step (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_wr_en,
    input  gbm_pkg::cfg_idx_t                   cfg_index,
    input  logic [gbm_pkg::CFG_DATA_W-1:0]      cfg_wdata,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  gbm_pkg::price_t                     s_current_price,
    input  logic signed [gbm_pkg::SAMPLE_W-1:0] s_normal_sample,

    output logic                                m_valid,
    input  logic                                m_ready,
    output gbm_pkg::price_t                     m_next_price,
    output logic                                m_saturated
);

    localparam int unsigned ST_IN      = 0;
    localparam int unsigned ST_SUM     = 1;
    localparam int unsigned ST_OFF     = 2;
    localparam int unsigned ST_QEST    = 3;
    localparam int unsigned ST_REM     = 4;
    localparam int unsigned ST_RED     = 5;
    localparam int unsigned ST_T0      = 6;
    localparam int unsigned ST_PROD    = ST_T0 + 3 * gbm_pkg::EXP_TERMS;
    localparam int unsigned ST_ROUND   = ST_PROD + 1;
    localparam int unsigned ST_OUT     = ST_PROD + 2;
    localparam int unsigned NUM_STAGES = ST_OUT + 1;
    localparam int unsigned NT         = gbm_pkg::EXP_TERMS;

    // configuration
    gbm_pkg::drift_t   drift_reg;
    gbm_pkg::std_dev_t std_reg;

    // flow control
    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] vld_next;
    logic [NUM_STAGES-1:0] rdy;

    // lines that follow the word down the pipe
    gbm_pkg::price_t price_line_reg [0:ST_PROD-1];
    gbm_pkg::kidx_t  q_line_reg     [ST_RED:ST_PROD];
    gbm_pkg::frac_t  r_line_reg     [ST_RED:ST_PROD-4];

    // range reduction
    gbm_pkg::dx_t     s0_drift_reg, s0_drift_next;
    gbm_pkg::dx_t     s0_smul_reg,  s0_smul_next;
    gbm_pkg::dx_t     s1_dx_reg,    s1_dx_next;
    gbm_pkg::dx_off_t s2_off_reg,   s2_off_next;
    gbm_pkg::dx_off_t s3_off_reg;
    gbm_pkg::kidx_t   s3_qest_reg,  s3_qest_next;
    gbm_pkg::rem_t    s4_rr_reg,    s4_rr_next;
    gbm_pkg::kidx_t   s4_q_reg;
    gbm_pkg::kidx_t   s5_q_next;
    gbm_pkg::frac_t   s5_r_next;

    logic [47:0]      dx_sum;
    logic [47:0]      off_sum;
    logic [31:0]      qmul;
    logic [46:0]      qln2;
    logic [46:0]      rem_full;
    logic [39:0]      r40;

    // series, one entry per term
    gbm_pkg::frac_t ta_x_reg   [0:NT-1];
    gbm_pkg::exp_t  ta_sum_reg [0:NT-1];
    gbm_pkg::frac_t tb_x_reg   [0:NT-1];
    gbm_pkg::frac_t tb_qe_reg  [0:NT-1];
    gbm_pkg::exp_t  tb_sum_reg [0:NT-1];
    gbm_pkg::frac_t tc_term_reg[0:NT-1];
    gbm_pkg::exp_t  tc_sum_reg [0:NT-1];

    // product, rounding, output
    logic [62:0]     fp_prod_reg, fp_prod_next;
    logic [63:0]     rd_sum_reg,  rd_sum_next;
    logic [5:0]      rd_amt_reg,  rd_amt_next;
    logic            rd_left_reg, rd_left_next;
    logic            rd_zero_reg, rd_zero_next;
    gbm_pkg::kidx_t  rd_shl;
    gbm_pkg::kidx_t  rd_shr;
    logic [63:0]     rd_half;
    logic [63:0]     out_shr;
    logic [63:0]     out_shl;
    logic [62:0]     out_over;
    gbm_pkg::price_t out_price_reg, out_price_next;
    logic            out_sat_reg,   out_sat_next;

    // ---------------------------------------------------------------
    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drift_reg <= '0;
            std_reg   <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                gbm_pkg::REG_LOG_DRIFT:   drift_reg <= cfg_wdata;
                gbm_pkg::REG_LOG_STD_DEV: std_reg   <= cfg_wdata[30:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // stage i moves when some stage at or below it is empty, or the
    // output word is being taken
    for (genvar i = 0; i < NUM_STAGES; i++) begin : g_rdy
        assign rdy[i] = m_ready || !(&vld_reg[NUM_STAGES-1:i]);
    end

    assign s_ready  = rdy[ST_IN];
    assign vld_next = {vld_reg[NUM_STAGES-2:0], s_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int i = 0; i < NUM_STAGES; i++) begin
                if (rdy[i]) begin
                    vld_reg[i] <= vld_next[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[ST_IN]) begin
            price_line_reg[ST_IN] <= s_current_price;
        end
    end

    for (genvar i = ST_IN + 1; i < ST_PROD; i++) begin : g_price_line
        always_ff @(posedge aclk) begin
            if (rdy[i]) begin
                price_line_reg[i] <= price_line_reg[i-1];
            end
        end
    end

    for (genvar i = ST_RED + 1; i <= ST_PROD; i++) begin : g_q_line
        always_ff @(posedge aclk) begin
            if (rdy[i]) begin
                q_line_reg[i] <= q_line_reg[i-1];
            end
        end
    end

    for (genvar i = ST_RED + 1; i <= ST_PROD - 4; i++) begin : g_r_line
        always_ff @(posedge aclk) begin
            if (rdy[i]) begin
                r_line_reg[i] <= r_line_reg[i-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // exponent: drift*4096 + sample*sd, clamp, bias, divide by ln2
    always_comb begin
        s0_drift_next = {{4{drift_reg[31]}}, drift_reg, 12'd0};
        s0_smul_next  = gbm_pkg::dx_t'(s_normal_sample)
                      * gbm_pkg::dx_t'($signed({1'b0, std_reg}));

        dx_sum = s0_drift_reg + s0_smul_reg;
        if ($signed(dx_sum) > gbm_pkg::DX_LIMIT) begin
            s1_dx_next = gbm_pkg::DX_LIMIT;
        end else if ($signed(dx_sum) < gbm_pkg::DX_LIMIT_NEG) begin
            s1_dx_next = gbm_pkg::DX_LIMIT_NEG;
        end else begin
            s1_dx_next = dx_sum;
        end

        off_sum     = $unsigned(s1_dx_reg) + {1'b0, gbm_pkg::DX_OFFSET};
        s2_off_next = off_sum[46:0];

        // estimate is the true index or one below it
        qmul         = 32'(s2_off_reg[gbm_pkg::HI_LSB +: gbm_pkg::HI_W])
                     * 32'(gbm_pkg::RECIP_LN2);
        s3_qest_next = qmul[gbm_pkg::RECIP_SHIFT +: 7];

        qln2       = 47'(s3_qest_reg) * 47'(gbm_pkg::LN2_Q40);
        rem_full   = s3_off_reg - qln2;
        s4_rr_next = rem_full[40:0];

        if (s4_rr_reg >= {1'b0, gbm_pkg::LN2_Q40}) begin
            r40       = 40'(s4_rr_reg - {1'b0, gbm_pkg::LN2_Q40});
            s5_q_next = s4_q_reg + 7'd1;
        end else begin
            r40       = s4_rr_reg[39:0];
            s5_q_next = s4_q_reg;
        end
        s5_r_next = r40[39:10];
    end

    always_ff @(posedge aclk) begin
        if (rdy[ST_IN]) begin
            s0_drift_reg <= s0_drift_next;
            s0_smul_reg  <= s0_smul_next;
        end
        if (rdy[ST_SUM]) begin
            s1_dx_reg <= s1_dx_next;
        end
        if (rdy[ST_OFF]) begin
            s2_off_reg <= s2_off_next;
        end
        if (rdy[ST_QEST]) begin
            s3_off_reg  <= s2_off_reg;
            s3_qest_reg <= s3_qest_next;
        end
        if (rdy[ST_REM]) begin
            s4_rr_reg <= s4_rr_next;
            s4_q_reg  <= s3_qest_reg;
        end
        if (rdy[ST_RED]) begin
            q_line_reg[ST_RED] <= s5_q_next;
            r_line_reg[ST_RED] <= s5_r_next;
        end
    end

    // ---------------------------------------------------------------
    // exp(r) series: term = ((term * r) >> 30) / n, sum += term
    for (genvar j = 0; j < NT; j++) begin : g_term
        localparam int unsigned ST_A = ST_T0 + 3 * j;
        localparam logic [31:0] TERM_RECIP =
            32'((64'd1 << gbm_pkg::TERM_RECIP_SHIFT) / 64'(j + 1));
        localparam gbm_pkg::frac_t TERM_DIV = 30'(j + 1);

        gbm_pkg::exp_t  t_in;
        gbm_pkg::exp_t  sum_in;
        logic [60:0]    a_prod;
        gbm_pkg::frac_t ta_x_next;
        logic [61:0]    b_prod;
        gbm_pkg::frac_t tb_qe_next;
        gbm_pkg::frac_t c_rem;
        gbm_pkg::frac_t tc_term_next;
        gbm_pkg::exp_t  tc_sum_next;

        if (j == 0) begin : g_first
            assign t_in   = gbm_pkg::ONE_Q30;
            assign sum_in = gbm_pkg::ONE_Q30;
        end else begin : g_next
            assign t_in   = {1'b0, tc_term_reg[j-1]};
            assign sum_in = tc_sum_reg[j-1];
        end

        always_comb begin
            a_prod    = 61'(t_in) * 61'(r_line_reg[ST_A-1]);
            ta_x_next = a_prod[59:30];

            b_prod     = 62'(ta_x_reg[j]) * 62'(TERM_RECIP);
            tb_qe_next = b_prod[gbm_pkg::TERM_RECIP_SHIFT +: 30];

            // quotient estimate is exact or one low
            c_rem = tb_x_reg[j] - 30'(tb_qe_reg[j] * TERM_DIV);
            if (c_rem >= TERM_DIV) begin
                tc_term_next = tb_qe_reg[j] + 30'd1;
            end else begin
                tc_term_next = tb_qe_reg[j];
            end
            tc_sum_next = tb_sum_reg[j] + {1'b0, tc_term_next};
        end

        always_ff @(posedge aclk) begin
            if (rdy[ST_A]) begin
                ta_x_reg[j]   <= ta_x_next;
                ta_sum_reg[j] <= sum_in;
            end
            if (rdy[ST_A+1]) begin
                tb_x_reg[j]   <= ta_x_reg[j];
                tb_qe_reg[j]  <= tb_qe_next;
                tb_sum_reg[j] <= ta_sum_reg[j];
            end
            if (rdy[ST_A+2]) begin
                tc_term_reg[j] <= tc_term_next;
                tc_sum_reg[j]  <= tc_sum_next;
            end
        end
    end

    // ---------------------------------------------------------------
    // price * exp(r), then scale by 2^(q - 88) with round half up
    always_comb begin
        fp_prod_next = 63'(price_line_reg[ST_PROD-1]) * 63'(tc_sum_reg[NT-1]);

        rd_shl = q_line_reg[ST_PROD] - gbm_pkg::Q_LEFT;
        rd_shr = gbm_pkg::Q_LEFT - q_line_reg[ST_PROD];
        rd_left_next = q_line_reg[ST_PROD] > gbm_pkg::Q_LEFT;
        rd_zero_next = 1'b0;
        rd_half      = '0;
        if (rd_left_next) begin
            rd_amt_next = rd_shl[5:0];
        end else begin
            rd_amt_next  = rd_shr[5:0];
            rd_zero_next = rd_shr[6];
            if (rd_shr[5:0] != 6'd0) begin
                rd_half = 64'd1 << (rd_shr[5:0] - 6'd1);
            end
        end
        rd_sum_next = {1'b0, fp_prod_reg} + rd_half;

        out_shr  = rd_sum_reg >> rd_amt_reg;
        out_shl  = rd_sum_reg << rd_amt_reg;
        out_over = rd_sum_reg[62:0] >> (6'd32 - rd_amt_reg);
        if (rd_left_reg) begin
            out_sat_next   = |out_over;
            out_price_next = out_sat_next ? gbm_pkg::MAX_PRICE : out_shl[31:0];
        end else if (rd_zero_reg) begin
            out_sat_next   = 1'b0;
            out_price_next = '0;
        end else begin
            out_sat_next   = |out_shr[63:32];
            out_price_next = out_sat_next ? gbm_pkg::MAX_PRICE : out_shr[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[ST_PROD]) begin
            fp_prod_reg <= fp_prod_next;
        end
        if (rdy[ST_ROUND]) begin
            rd_sum_reg  <= rd_sum_next;
            rd_amt_reg  <= rd_amt_next;
            rd_left_reg <= rd_left_next;
            rd_zero_reg <= rd_zero_next;
        end
        if (rdy[ST_OUT]) begin
            out_price_reg <= out_price_next;
            out_sat_reg   <= out_sat_next;
        end
    end

    assign m_valid      = vld_reg[ST_OUT];
    assign m_next_price = out_price_reg;
    assign m_saturated  = out_sat_reg;

    // ---------------------------------------------------------------
    a_sat_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_saturated |-> m_next_price == gbm_pkg::MAX_PRICE)
        else $error("saturated word without all-ones price");

    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (&vld_reg) && !m_ready)
        else $error("input stalled while a stage is empty or output drains");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid right after reset");

    a_red_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[ST_RED] |-> q_line_reg[ST_RED] <= gbm_pkg::Q_MAX)
        else $error("range reduction index out of range");

    a_exp_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[ST_PROD-1] |-> tc_sum_reg[NT-1] >= gbm_pkg::ONE_Q30)
        else $error("exp series below one");

endmodule
